// ===== hw/rtl/pmc_pkg.sv =====
// shared types, constants and helpers for the palindrome min-cut core
package pmc_pkg;

   localparam int MAX_LEN = 256;
   localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   // internal cut count never exceeds MAX_LEN - 1
   localparam int CUT_W   = ADDR_W;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] prefix_cuts;
      logic       overflow;
      logic       done_res;
   } rsp_type;

   // clamp an internal cut count to the 8-bit result field
   function automatic logic [7:0] sat_cuts(input logic [CUT_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w > 32'd255) begin
         return 8'hff;
      end
      return w[7:0];
   endfunction

endpackage

// ===== hw/rtl/palindrome_min_cut_core.sv =====
// palindrome min-cut core: streaming least-cut palindrome partition of a byte string
//
// usage
// - req channel: one character per item (ch, last); last ends the string
// - rsp channel: one item per character with the least cut count of the prefix
//   so far, the sticky overflow flag and a copy of last (done_res)
// - a character at position i (from 0) walks all start positions 0..i, one per
//   cycle, through one compare/add/min unit fed by the three stores
// - from accept an item goes through the scan, drain and finish steps; a character
//   beyond MAX_LEN takes the overflow step and repeats the full stored prefix's cut count
// - req_ready is high only while the core is idle, so a new item is accepted only
//   once the last one has left the finish step, which waits while rsp is stalled
// - a finished item sits in the output register; a new item is accepted meanwhile,
//   and its result waits in the finish step until the rsp side takes the old one
// - reset clears the string length, the overflow flag and all handshake state;
//   the stores are not cleared, only entries of the current string are read
// - after an item with last set the length and overflow flag return to zero
module palindrome_min_cut_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pmc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pmc_pkg::rsp_type rsp_data
);
   import pmc_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_OVF    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // the three stores, one write and one read port each
   logic [7:0]       char_mem [MAX_LEN];
   logic             pal_mem  [MAX_LEN];
   logic [CUT_W-1:0] cut_mem  [MAX_LEN];

   logic [2:0]        state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_flag_ff, ovf_flag_in;
   logic [ADDR_W-1:0] j_ff, j_in;          // read issue position
   logic [ADDR_W-1:0] i_ff, i_in;          // position of the current character
   logic [7:0]        c_ff, c_in;
   logic              last_ff, last_in;
   logic              ovf_item_ff, ovf_item_in;
   logic [CUT_W-1:0]  best_ff, best_in;
   logic              proc_v_ff, proc_v_in;
   logic [ADDR_W-1:0] proc_j_ff, proc_j_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // registered read data
   logic [7:0]       chr_rd_ff;
   logic             pal_rd_ff;
   logic [CUT_W-1:0] cut_rd_ff;

   logic              accept;
   logic              full;
   logic              out_free;
   logic [ADDR_W-1:0] char_raddr, pal_raddr, cut_raddr;
   logic [ADDR_W-1:0] span;
   logic              pal_hit;
   logic [CUT_W-1:0]  cand;
   logic              pal_we;
   logic              cut_we;
   logic              char_we;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (len_ff == LEN_W'(MAX_LEN));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // read addresses: character at j, inner flag at j+1, cuts of prefix ending at j-1
   always_comb begin
      char_raddr = j_ff;
      pal_raddr  = j_ff + ADDR_W'(1);
      cut_raddr  = j_ff - ADDR_W'(1);
      if (state_ff == ST_IDLE) begin
         // overflow path needs the cut count of the full prefix
         cut_raddr = ADDR_W'(MAX_LEN - 1);
      end
   end

   // the shared compare and min unit for one start position
   assign span    = i_ff - proc_j_ff;
   assign pal_hit = (chr_rd_ff == c_ff) && ((span < ADDR_W'(2)) || pal_rd_ff);
   assign cand    = cut_rd_ff + CUT_W'(1);
   assign pal_we  = proc_v_ff;
   assign char_we = accept && !full;
   assign cut_we  = (state_ff == ST_FINISH) && out_free && !ovf_item_ff;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ovf_flag_in  = ovf_flag_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      c_in         = c_ff;
      last_in      = last_ff;
      ovf_item_in  = ovf_item_ff;
      best_in      = best_ff;
      proc_v_in    = (state_ff == ST_SCAN);
      proc_j_in    = j_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // fold in the start position whose store data arrived this cycle
      if (proc_v_ff && pal_hit) begin
         if (proc_j_ff == '0) begin
            best_in = '0;
         end else if (cand < best_ff) begin
            best_in = cand;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               c_in    = req_data.ch;
               last_in = req_data.last;
               j_in    = '0;
               if (full) begin
                  ovf_item_in = 1'b1;
                  state_in    = ST_OVF;
               end else begin
                  ovf_item_in = 1'b0;
                  i_in        = len_ff[ADDR_W-1:0];
                  best_in     = CUT_W'(len_ff[ADDR_W-1:0]);
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (j_ff == i_ff) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_OVF: begin
            best_in  = cut_rd_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.prefix_cuts  = sat_cuts(best_ff);
               rsp_in.overflow     = ovf_flag_ff || ovf_item_ff;
               rsp_in.done_res     = last_ff;
               ovf_flag_in         = ovf_flag_ff || ovf_item_ff;
               if (!ovf_item_ff) begin
                  len_in = len_ff + LEN_W'(1);
               end
               if (last_ff) begin
                  len_in      = '0;
                  ovf_flag_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_flag_ff  <= 1'b0;
         proc_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_flag_ff  <= ovf_flag_in;
         proc_v_ff    <= proc_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      i_ff        <= i_in;
      c_ff        <= c_in;
      last_ff     <= last_in;
      ovf_item_ff <= ovf_item_in;
      best_ff     <= best_in;
      proc_j_ff   <= proc_j_in;
      rsp_ff      <= rsp_in;
   end

   // character store
   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[len_ff[ADDR_W-1:0]] <= req_data.ch;
      end
      chr_rd_ff <= char_mem[char_raddr];
   end

   // palindrome column, replaced in place in ascending order
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[proc_j_ff] <= pal_hit;
      end
      pal_rd_ff <= pal_mem[pal_raddr];
   end

   // least cuts per prefix
   always_ff @(posedge clock) begin
      if (cut_we) begin
         cut_mem[i_ff] <= best_ff;
      end
      cut_rd_ff <= cut_mem[cut_raddr];
   end

endmodule

// ===== verif/palindrome_min_cut_core_tb.sv =====
// testbench for the palindrome min-cut core: directed strings, then random strings checked by a predictor
`timescale 1ns / 1ps

module palindrome_min_cut_core_tb;
   import pmc_pkg::*;

   // shapes of random strings
   typedef enum int {
      STR_BYTES,   // any byte value, few palindromes
      STR_ALPHA,   // one to three symbols, palindromes everywhere
      STR_MIRROR,  // whole string reads the same both ways
      STR_CYCLE    // three distinct symbols in rotation, no palindrome beyond one char
   } str_kind_type;

   // one row of the directed table; fixed rows carry a cut count read off by hand
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       fixed;
      logic [7:0] cuts;
   } dir_row_type;

   localparam int DIR_ROWS = 24;
   localparam int PHASE_ITEMS = 300;
   localparam int DRAIN_CYCLES = MAX_LEN + 16;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // predictor state
   logic [7:0]       char_mem [0:MAX_LEN-1];
   logic             pal_col  [0:MAX_LEN];
   logic [CUT_W-1:0] cut_mem  [0:MAX_LEN-1];
   logic [LEN_W-1:0] str_len;
   logic             ovf_flag;

   rsp_type pending_cuts [$];
   int      fault_count = 0;
   int      sent_count = 0;
   int      send_gap_pct = 13;
   int      rsp_stall_pct = 76;

   dir_row_type dir_table [0:DIR_ROWS-1] = '{
      // single chars at both byte extremes
      '{8'h00, 1'b1, 1'b1, 8'd0},
      '{8'hff, 1'b1, 1'b1, 8'd0},
      // odd palindrome over extreme bytes
      '{8'h00, 1'b0, 1'b1, 8'd0},
      '{8'hff, 1'b0, 1'b1, 8'd1},
      '{8'h00, 1'b1, 1'b1, 8'd0},
      // even palindrome then a tail
      '{8'h55, 1'b0, 1'b0, 8'd0},
      '{8'haa, 1'b0, 1'b0, 8'd0},
      '{8'haa, 1'b0, 1'b0, 8'd0},
      '{8'h55, 1'b0, 1'b0, 8'd0},
      '{8'haa, 1'b1, 1'b0, 8'd0},
      // all distinct: one cut per extra char
      '{8'h01, 1'b0, 1'b1, 8'd0},
      '{8'h02, 1'b0, 1'b1, 8'd1},
      '{8'h03, 1'b0, 1'b1, 8'd2},
      '{8'h04, 1'b1, 1'b1, 8'd3},
      // alternating pair
      '{8'h7f, 1'b0, 1'b0, 8'd0},
      '{8'h80, 1'b0, 1'b0, 8'd0},
      '{8'h7f, 1'b0, 1'b0, 8'd0},
      '{8'h80, 1'b1, 1'b0, 8'd0},
      // run of one symbol
      '{8'h11, 1'b0, 1'b1, 8'd0},
      '{8'h11, 1'b0, 1'b1, 8'd0},
      '{8'h11, 1'b1, 1'b1, 8'd0},
      // pair at the tail
      '{8'ha5, 1'b0, 1'b0, 8'd0},
      '{8'h5a, 1'b0, 1'b0, 8'd0},
      '{8'h5a, 1'b1, 1'b0, 8'd0}
   };

   palindrome_min_cut_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // least cut count after one more char, advancing the predictor state
   function automatic rsp_type next_min_cut(input req_type item);
      rsp_type          r;
      logic [LEN_W-1:0] best;
      logic             hit;
      int               pos;
      int               j;
      if (str_len == LEN_W'(MAX_LEN)) begin
         // string full: char dropped, cut count of the full prefix repeated
         ovf_flag = 1'b1;
         best = LEN_W'(cut_mem[MAX_LEN-1]);
      end else begin
         pos = int'(str_len);
         char_mem[pos] = item.ch;
         best = LEN_W'(pos);
         // ascending start, so pal_col[j + 1] still holds the previous column
         for (j = 0; j <= pos; j++) begin
            hit = (char_mem[j] == item.ch) && ((pos - j < 2) || pal_col[j + 1]);
            pal_col[j] = hit;
            if (hit) begin
               if (j == 0) begin
                  best = '0;
               end else if (LEN_W'(cut_mem[j-1]) + LEN_W'(1) < best) begin
                  best = LEN_W'(cut_mem[j-1]) + LEN_W'(1);
               end
            end
         end
         cut_mem[pos] = best[CUT_W-1:0];
         str_len = LEN_W'(pos + 1);
      end
      r.prefix_cuts = (best > LEN_W'(255)) ? 8'hff : best[7:0];
      r.overflow = ovf_flag;
      r.done_res = item.last;
      if (item.last) begin
         str_len = '0;
         ovf_flag = 1'b0;
      end
      return r;
   endfunction

   // offer one char with random gaps, then queue its expected result on acceptance
   task automatic push_char(input req_type item, input logic fixed, input logic [7:0] cuts);
      rsp_type want;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      want = next_min_cut(item);
      if (fixed) begin
         want.prefix_cuts = cuts;
         want.overflow = 1'b0;
         want.done_res = item.last;
      end
      pending_cuts.push_back(want);
      sent_count++;
   endtask

   // build one string of the given shape and send it, last set on its final char
   task automatic send_string(input int len, input str_kind_type kind);
      logic [7:0] text [$];
      logic [7:0] alpha [0:2];
      req_type    item;
      int         n_sym;
      int         k;
      alpha[0] = 8'($urandom_range(255));
      alpha[1] = alpha[0] + 8'd1 + 8'($urandom_range(80));
      alpha[2] = alpha[1] + 8'd1 + 8'($urandom_range(80));
      n_sym = $urandom_range(1, 3);
      for (k = 0; k < len; k++) begin
         case (kind)
            STR_BYTES: begin
               text.push_back(8'($urandom_range(255)));
            end
            STR_ALPHA: begin
               text.push_back(alpha[$urandom_range(n_sym - 1)]);
            end
            STR_MIRROR: begin
               if (k < (len + 1) / 2) begin
                  text.push_back(alpha[$urandom_range(n_sym - 1)]);
               end else begin
                  text.push_back(text[len - 1 - k]);
               end
            end
            default: begin
               text.push_back(alpha[k % 3]);
            end
         endcase
      end
      for (k = 0; k < len; k++) begin
         item.ch = text[k];
         item.last = (k == len - 1);
         push_char(item, 1'b0, 8'd0);
      end
   endtask

   // result side: compare each accepted item with the oldest expectation, stall at random
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cuts.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, rsp_data);
            fault_count++;
         end else begin
            want = pending_cuts.pop_front();
            if (rsp_data.prefix_cuts !== want.prefix_cuts) begin
               $display("%0t: prefix_cuts expected %0d, got %0d",
                        $time, want.prefix_cuts, rsp_data.prefix_cuts);
               fault_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $display("%0t: overflow expected %0d, got %0d",
                        $time, want.overflow, rsp_data.overflow);
               fault_count++;
            end
            if (rsp_data.done_res !== want.done_res) begin
               $display("%0t: done_res expected %0d, got %0d",
                        $time, want.done_res, rsp_data.done_res);
               fault_count++;
            end
         end
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin : stimulus
      req_type item;
      int      r;
      int      phase;
      int      len;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      str_len = '0;
      ovf_flag = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table, walked under the first idling mix
      for (r = 0; r < DIR_ROWS; r++) begin
         item.ch = dir_table[r].ch;
         item.last = dir_table[r].last;
         push_char(item, dir_table[r].fixed, dir_table[r].cuts);
      end

      // random strings in three idling mixes: sender light, receiver light, none
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 13;
               rsp_stall_pct = 76;
               // rotation of three symbols runs the cut count to 255, then overflows
               send_string($urandom_range(MAX_LEN + 1, MAX_LEN + 3), STR_CYCLE);
            end
            1: begin
               send_gap_pct = 76;
               rsp_stall_pct = 13;
            end
            default: begin
               send_gap_pct = 0;
               rsp_stall_pct = 0;
               // dense palindromes over the full length, then overflow
               send_string($urandom_range(MAX_LEN + 1, MAX_LEN + 6), STR_ALPHA);
            end
         endcase
         while (sent_count < DIR_ROWS + (phase + 1) * PHASE_ITEMS) begin
            // mostly short strings, now and then a medium one
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            send_string(len, str_kind_type'($urandom_range(3)));
         end
      end
      req_valid <= 1'b0;

      // drain, then allow one full walk for any stray result
      while (pending_cuts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("palindrome_min_cut_core_tb: clean");
      end else begin
         $display("palindrome_min_cut_core_tb: errors");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("palindrome_min_cut_core_tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/pmc_pkg.sv
hw/rtl/palindrome_min_cut_core.sv
verif/palindrome_min_cut_core_tb.sv
